@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bitmap id allocator assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define BIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap id allocator assertion failed");

`endif

@@ rtl/bia_pkg.sv @@
// Package with types, codes and constants of the bitmap identifier allocator.
package bia_pkg;

  // Geometry of the bitmap: 32-bit words, 8-bit identifiers
  localparam int MAP_SIZE = 256;
  localparam int WORD_W   = 32;
  localparam int WORD_LSB = 5;
  localparam int ID_W     = 8;

  // Word 0 holds the reserved identifier 0, marked used at reset
  localparam logic [WORD_W-1:0] WORD0_RESET = 32'h0000_0001;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // item accepted this cycle
    logic look;      // data of the addressed word is on the read port
    logic scan;      // data of the current scan word is on the read port
    logic load_out;  // move the result into the output register
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_op;       // incoming command is one of the three real commands
    logic alloc_miss;  // allocate found the hint taken or out of range, fall back to the scan
    logic scan_found;  // scan word holds a free identifier
    logic scan_last;   // scan is on the last word
  } dp_stat_t;

endpackage

@@ rtl/bia_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bia_ctrl.sv @@
// Controller state machine of the bitmap identifier allocator.
module bia_ctrl import bia_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.in_op ? S_LOOK : S_RESP;
        end
      end
      S_LOOK: begin
        state_nxt = stat.alloc_miss ? S_SCAN : S_RESP;
      end
      S_SCAN: begin
        if (stat.scan_found || stat.scan_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_LOOK: cmd.look = 1'b1;
      S_SCAN: cmd.scan = 1'b1;
      S_RESP: cmd.load_out = !out_valid_r || out_ready;
      default: cmd = '0;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/bia_dp.sv @@
// Datapath of the bitmap identifier allocator: bitmap RAM, hint, scan and result.
module bia_dp import bia_pkg::*; #(
  parameter int ID_COUNT   = 256,
  parameter int FIRST_HINT = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_cmd,
  input  logic [ID_W-1:0] in_ident,
  output logic [ID_W-1:0] out_ident_out,
  output logic [1:0]      out_status,
  input  ctl_cmd_t        cmd,
  output dp_stat_t        stat
);

  localparam int LIMIT  = (ID_COUNT > MAP_SIZE) ? MAP_SIZE : ID_COUNT;
  localparam int WORDS  = (LIMIT + WORD_W - 1) / WORD_W;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [ID_W:0] LIM9 = (ID_W+1)'(LIMIT);

  logic [1:0]        cmd_r;
  logic [ID_W-1:0]   ident_r;
  logic [ID_W-1:0]   hint_r, hint_nxt;
  logic [ADDR_W-1:0] scan_r, scan_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic              rd_en;
  logic [WORDS-1:0]  rowv_r;
  logic              rv_q_r;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  logic [ID_W-1:0]   out_ident_r;
  logic [1:0]        out_status_r;

  logic [WORD_W-1:0] ram_q, word, wdata;
  logic              we;

  logic [ID_W-1:0]   key, in_key;
  logic [ID_W-1:0]   in_key_word;
  logic              key_ok, key_used, look_hit;
  logic [WORD_W-1:0] key_bit;

  logic [ID_W:0]     scan_base;
  logic [WORD_W-1:0] free_mask;
  logic              found;
  logic [WORD_LSB-1:0] pos;
  logic [ID_W-1:0]   scan_id;
  logic              last;

  // Hint after granting an identifier, wrapping to 1
  function automatic logic [ID_W-1:0] next_hint(input logic [ID_W-1:0] id);
    next_hint = ({1'b0, id} < LIM9 - (ID_W+1)'(1)) ? id + ID_W'(1) : ID_W'(1);
  endfunction

  bia_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (rd_addr_r),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr_nxt),
    .rdata (ram_q)
  );

  // Word seen on the read port; a row never written reads as its reset value
  assign word = rv_q_r ? ram_q : ((rd_addr_r == '0) ? WORD0_RESET : '0);

  // Identifier looked at: the hint on allocate, the item's identifier otherwise
  assign key         = (cmd_r == CMD_ALLOC) ? hint_r : ident_r;
  assign in_key      = (in_cmd == CMD_ALLOC) ? hint_r : in_ident;
  assign in_key_word = in_key >> WORD_LSB;
  assign key_ok      = (key != '0) && ({1'b0, key} < LIM9);
  assign key_used    = word[key[WORD_LSB-1:0]];
  assign key_bit     = WORD_W'(1) << key[WORD_LSB-1:0];
  assign look_hit    = key_ok && !key_used;

  // Free identifiers in the scan word, lowest one wins
  assign scan_base = (ID_W+1)'(scan_r) << WORD_LSB;

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      free_mask[j] = !word[j] && ((scan_base + (ID_W+1)'(j)) != '0)
                     && ((scan_base + (ID_W+1)'(j)) < LIM9);
    end
  end

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_mask[j]) begin
        found = 1'b1;
        pos   = WORD_LSB'(j);
      end
    end
  end

  assign scan_id = ID_W'(scan_base + (ID_W+1)'(pos));
  assign last    = (scan_r == ADDR_W'(WORDS - 1));

  // Status to the controller
  assign stat.in_op      = (in_cmd != CMD_RSVD);
  assign stat.alloc_miss = (cmd_r == CMD_ALLOC) && !look_hit;
  assign stat.scan_found = found;
  assign stat.scan_last  = last;

  // Read address, write-back, hint and result
  always_comb begin
    rd_en       = 1'b0;
    rd_addr_nxt = rd_addr_r;
    we          = 1'b0;
    wdata       = word;
    hint_nxt    = hint_r;
    scan_nxt    = scan_r;
    res_id_nxt  = res_id_r;
    res_st_nxt  = res_st_r;
    if (cmd.start) begin
      rd_en       = 1'b1;
      rd_addr_nxt = in_key_word[ADDR_W-1:0];
      res_id_nxt  = in_ident;
      res_st_nxt  = ST_BAD;
    end else if (cmd.look) begin
      case (cmd_r)
        CMD_ALLOC: begin
          if (look_hit) begin
            we         = 1'b1;
            wdata      = word | key_bit;
            res_id_nxt = hint_r;
            res_st_nxt = ST_OK;
            hint_nxt   = next_hint(hint_r);
          end else begin
            rd_en       = 1'b1;
            rd_addr_nxt = '0;
            scan_nxt    = '0;
          end
        end
        CMD_FREE: begin
          if (key_ok && key_used) begin
            we         = 1'b1;
            wdata      = word & ~key_bit;
            res_st_nxt = ST_OK;
          end else begin
            res_st_nxt = ST_BAD;
          end
        end
        CMD_CHECK: res_st_nxt = look_hit ? ST_OK : ST_BUSY;
        default:   res_st_nxt = ST_BAD;
      endcase
    end else if (cmd.scan) begin
      if (found) begin
        we         = 1'b1;
        wdata      = word | (WORD_W'(1) << pos);
        res_id_nxt = scan_id;
        res_st_nxt = ST_OK;
        hint_nxt   = next_hint(scan_id);
      end else if (last) begin
        res_id_nxt = '0;
        res_st_nxt = ST_BUSY;
      end else begin
        scan_nxt    = scan_r + ADDR_W'(1);
        rd_en       = 1'b1;
        rd_addr_nxt = scan_r + ADDR_W'(1);
      end
    end
  end

  // Control state: hint and row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hint_r <= ID_W'(FIRST_HINT);
      rowv_r <= '0;
    end else begin
      hint_r <= hint_nxt;
      if (we) begin
        rowv_r[rd_addr_r] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r   <= in_cmd;
      ident_r <= in_ident;
    end
    if (rd_en) begin
      rd_addr_r <= rd_addr_nxt;
      rv_q_r    <= rowv_r[rd_addr_nxt];
    end
    scan_r   <= scan_nxt;
    res_id_r <= res_id_nxt;
    res_st_r <= res_st_nxt;
    if (cmd.load_out) begin
      out_ident_r  <= res_id_r;
      out_status_r <= res_st_r;
    end
  end

  assign out_ident_out = out_ident_r;
  assign out_status    = out_status_r;

endmodule

@@ rtl/bitmap_id_allocator_core.sv @@
// After acceptance, command 3 goes straight to the response state; check, free and an
// allocate that takes the hint first read the addressed bitmap word, and an allocate
// that misses the hint then scans the bitmap words from word 0 (up to 8 words). One item
// at a time: the next item is taken only after the result is loaded; bitmap RAM of at most 8 x 32.
// Reset (synchronous, rst_n low) clears the controller and the row valid bits and sets
// the hint to FIRST_HINT; rows never written read as their reset value, so no clearing pass is needed.
module bitmap_id_allocator_core import bia_pkg::*; #(
  parameter int ID_COUNT   = 256,
  parameter int FIRST_HINT = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_cmd,
  input  logic [ID_W-1:0] in_ident,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] out_ident_out,
  output logic [1:0]      out_status
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bia_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bia_dp #(
    .ID_COUNT   (ID_COUNT),
    .FIRST_HINT (FIRST_HINT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_cmd),
    .in_ident      (in_ident),
    .out_ident_out (out_ident_out),
    .out_status    (out_status),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

@@ rtl/bia_checker.sv @@
// Port-level checker of the bitmap identifier allocator and its bind.
`include "assert_macros.svh"

module bia_checker import bia_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ID_W-1:0] out_ident_out,
  input logic [1:0]      out_status
);

  // A stalled result stays offered with the same payload
  `BIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BIA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                   $stable(out_ident_out) && $stable(out_status))
  // One item in flight: no second item taken right after one is accepted
  `BIA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // Status code 3 is never produced
  `BIA_ASSERT(a_status_code, !out_valid || (out_status != 2'd3))

endmodule

bind bitmap_id_allocator_core bia_checker u_bia_checker (.*);

@@ tb/tb_bitmap_id_allocator_core.sv @@
// Self-checking testbench for bitmap_id_allocator_core: directed and random traffic.
`timescale 1ns / 1ps

module tb_bitmap_id_allocator_core;
  import bia_pkg::*;

  localparam int ID_COUNT     = 256;
  localparam int FIRST_HINT   = 1;
  localparam int ID_LIMIT     = (ID_COUNT > MAP_SIZE) ? MAP_SIZE : ID_COUNT;
  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 7;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 24;

  // One reply of the allocator
  typedef struct packed {
    logic [ID_W-1:0] ident;
    logic [1:0]      status;
  } reply_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  logic [1:0]      in_cmd    = CMD_CHECK;
  logic [ID_W-1:0] in_ident  = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [ID_W-1:0] out_ident_out;
  logic [1:0]      out_status;

  // Predicted allocator state
  logic [MAP_SIZE-1:0] id_used;
  int                  next_hint;

  reply_t pending_replies[$];
  int     error_count  = 0;
  int     burst_left   = 0;
  int     stall_cycles = 0;
  bit     hold_req     = 1'b0;

  bitmap_id_allocator_core #(
    .ID_COUNT  (ID_COUNT),
    .FIRST_HINT(FIRST_HINT)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_ident     (in_ident),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ident_out(out_ident_out),
    .out_status   (out_status)
  );

  // Clock
  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic bit id_is_free(int id);
    return (id >= 1) && (id < ID_LIMIT) && !id_used[id];
  endfunction

  function automatic int count_free_ids();
    int n;
    n = 0;
    for (int i = 1; i < ID_LIMIT; i++) n += id_is_free(i);
    return n;
  endfunction

  // Random identifier currently in use, 0 when none is
  function automatic int pick_used_id();
    int start;
    int id;
    start = $urandom_range(1, ID_LIMIT - 1);
    for (int k = 0; k < ID_LIMIT - 1; k++) begin
      id = 1 + ((start - 1 + k) % (ID_LIMIT - 1));
      if (id_used[id]) return id;
    end
    return 0;
  endfunction

  // Applies one command to the predicted state and returns the reply it gives
  function automatic reply_t compute_reply(logic [1:0] cmd, logic [ID_W-1:0] ident);
    reply_t r;
    int     grant;
    r.ident  = ident;
    r.status = ST_BAD;
    case (cmd)
      CMD_ALLOC: begin
        r.ident  = '0;
        r.status = ST_BUSY;
        grant    = -1;
        // next fit at the hint, else lowest free from 1 upward
        if (id_is_free(next_hint)) begin
          grant = next_hint;
        end else begin
          for (int i = 1; i < ID_LIMIT; i++) begin
            if (id_is_free(i)) begin
              grant = i;
              break;
            end
          end
        end
        if (grant >= 0) begin
          id_used[grant] = 1'b1;
          next_hint      = (grant < ID_LIMIT - 1) ? grant + 1 : 1;
          r.ident        = grant[ID_W-1:0];
          r.status       = ST_OK;
        end
      end
      CMD_FREE: begin
        if (ident >= 1 && ident < ID_LIMIT && id_used[ident]) begin
          id_used[ident] = 1'b0;
          r.status       = ST_OK;
        end
      end
      CMD_CHECK: begin
        r.status = id_is_free(ident) ? ST_OK : ST_BUSY;
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    return r;
  endfunction

  // Offers one item in bursts with random gaps; predicts its reply on acceptance
  task automatic send_item(logic [1:0] cmd, logic [ID_W-1:0] ident);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_ident <= ident;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(compute_reply(cmd, ident));
  endtask

  // Receiver: ready pattern changes per segment, long hold-off on request
  initial begin
    int seg_left;
    int ready_pct;
    seg_left  = 0;
    ready_pct = 100;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 70;
          2: ready_pct = 35;
          default: ready_pct = 8;
        endcase
        seg_left = $urandom_range(20, 200);
      end
      seg_left--;
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin : result_check
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: ident_out %0d status %0d", out_ident_out, out_status);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_ident_out !== want.ident) begin
          $error("ident_out mismatch: expected %0d, actual %0d", want.ident, out_ident_out);
          error_count++;
        end
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** bitmap_id_allocator_core: FAILED **");
      $finish;
    end
  end

  // Fresh map: checks and frees at the edges, reserved command
  task automatic test_reset_state();
    send_item(CMD_CHECK, 8'd0);
    send_item(CMD_CHECK, 8'd1);
    send_item(CMD_CHECK, 8'd255);
    send_item(CMD_FREE, 8'd0);
    send_item(CMD_FREE, 8'd255);
    send_item(CMD_RSVD, 8'h00);
    send_item(CMD_RSVD, 8'hFF);
  endtask

  // Allocate along the hint, free, double free, check
  task automatic test_basic_ops();
    send_item(CMD_ALLOC, 8'hFF);
    send_item(CMD_ALLOC, 8'h00);
    send_item(CMD_ALLOC, 8'hA5);
    send_item(CMD_CHECK, 8'd2);
    send_item(CMD_FREE, 8'd2);
    send_item(CMD_FREE, 8'd2);
    send_item(CMD_CHECK, 8'd2);
    send_item(CMD_ALLOC, 8'd0);
    send_item(CMD_FREE, 8'd1);
    send_item(CMD_CHECK, 8'h55);
    send_item(CMD_RSVD, 8'hAA);
    send_item(CMD_FREE, 8'hAA);
  endtask

  // Fill the whole map through the hint wrap, allocate when full, then reuse holes
  task automatic test_fill_and_wrap();
    while (count_free_ids() > 0) send_item(CMD_ALLOC, ID_W'($urandom_range(0, 255)));
    send_item(CMD_ALLOC, 8'd0);
    send_item(CMD_ALLOC, 8'd255);
    send_item(CMD_CHECK, 8'd255);
    send_item(CMD_FREE, 8'd255);
    send_item(CMD_FREE, 8'd200);
    send_item(CMD_FREE, 8'd7);
    send_item(CMD_ALLOC, 8'd0);
    send_item(CMD_ALLOC, 8'd0);
    send_item(CMD_ALLOC, 8'd0);
    send_item(CMD_ALLOC, 8'd0);
    send_item(CMD_FREE, 8'd255);
    send_item(CMD_ALLOC, 8'd0);
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int k = 0; k < 12; k++) begin
      send_item(logic'($urandom_range(0, 1)) ? CMD_ALLOC : CMD_CHECK,
                ID_W'($urandom_range(0, 255)));
    end
  endtask

  // Alternating fill and drain phases with random operands
  task automatic test_random_traffic(int n_items);
    int  sel;
    int  phase_left;
    int  alloc_pct;
    int  free_pct;
    bit  fill_phase;
    phase_left = 0;
    fill_phase = 1'b0;
    for (int k = 0; k < n_items; k++) begin
      if (phase_left == 0) begin
        fill_phase = !fill_phase;
        phase_left = $urandom_range(100, 400);
      end
      phase_left--;
      alloc_pct = fill_phase ? 70 : 15;
      free_pct  = fill_phase ? 12 : 55;
      sel = $urandom_range(0, 99);
      if (sel < alloc_pct) begin
        send_item(CMD_ALLOC, ID_W'($urandom_range(0, 255)));
      end else if (sel < alloc_pct + free_pct) begin
        send_item(CMD_FREE, ID_W'(pick_used_id()));
      end else if (sel < alloc_pct + free_pct + 8) begin
        send_item(CMD_FREE, ID_W'($urandom_range(0, 255)));
      end else if (sel < 97) begin
        send_item(CMD_CHECK, ID_W'($urandom_range(0, 255)));
      end else begin
        send_item(CMD_RSVD, ID_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Sequence of tests and end of run
  initial begin
    id_used    = '0;
    id_used[0] = 1'b1;
    next_hint  = FIRST_HINT;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_basic_ops();
    test_fill_and_wrap();
    test_output_backpressure();
    test_random_traffic(600);
    test_output_backpressure();
    test_random_traffic(630);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("** bitmap_id_allocator_core: PASSED **");
    end else begin
      $display("** bitmap_id_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bia_pkg.sv
rtl/bia_ram.sv
rtl/bia_ctrl.sv
rtl/bia_dp.sv
rtl/bitmap_id_allocator_core.sv
rtl/bia_checker.sv
tb/tb_bitmap_id_allocator_core.sv
